### sv/fscp_pkg.sv
`timescale 1ns / 1ps
// shared constants and types of the fuzzy set clip point block
package fscp_pkg;

  localparam int PW     = 16;
  localparam int DW     = PW + 1;
  localparam int DEG_W  = 16;
  localparam int EPS_W  = 8;
  localparam int FRAC   = 15;
  localparam int PROD_W = DW + DEG_W + 1;
  localparam int TW     = PROD_W + 1;
  localparam int VMAX   = 5;
  localparam int CNT_W  = $clog2(VMAX + 1);
  localparam int IDX_W  = $clog2(VMAX);

  localparam logic [DEG_W-1:0]         ONE_Q15    = DEG_W'(1 << FRAC);
  localparam logic [EPS_W-1:0]         EPS_RESET  = EPS_W'(1);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC - 1));

  typedef struct packed {
    logic signed [PW-1:0] a;
    logic signed [PW-1:0] b;
    logic signed [PW-1:0] c;
    logic signed [PW-1:0] d;
    logic [DEG_W-1:0]     p;
  } fscp_set_t;

  typedef struct packed {
    logic p_zero;
    logic p_full;
    logic ab_ne;
    logic bc_eq;
    logic ad_eq;
    logic cd_eq;
    logic narrow;
  } fscp_flags_t;

  typedef struct packed {
    fscp_set_t            set;
    fscp_flags_t          flags;
    logic signed [DW-1:0] ba;
    logic signed [DW-1:0] dc;
    logic signed [DW-1:0] da;
  } fscp_diff_t;

  typedef struct packed {
    fscp_set_t                set;
    fscp_flags_t              flags;
    logic signed [PROD_W-1:0] prod_l;
    logic signed [PROD_W-1:0] prod_r;
    logic signed [DW-1:0]     da;
  } fscp_prod_t;

  typedef struct packed {
    fscp_set_t            set;
    fscp_flags_t          flags;
    logic signed [PW-1:0] left_x;
    logic signed [PW-1:0] right_x;
  } fscp_shld_t;

  typedef struct packed {
    logic signed [PW-1:0] x;
    logic [DEG_W-1:0]     y;
  } fscp_vtx_t;

endpackage

### sv/fscp_in_if.sv
`timescale 1ns / 1ps
// request channel carrying one trapezoidal set and its firing degree
interface fscp_in_if import fscp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [PW-1:0] corner_a;
  logic signed [PW-1:0] corner_b;
  logic signed [PW-1:0] corner_c;
  logic signed [PW-1:0] corner_d;
  logic [DEG_W-1:0]     firing_degree;

  modport source (output valid, output corner_a, output corner_b, output corner_c,
                  output corner_d, output firing_degree, input ready);
  modport sink (input valid, input corner_a, input corner_b, input corner_c,
                input corner_d, input firing_degree, output ready);
endinterface

### sv/fscp_out_if.sv
`timescale 1ns / 1ps
// result channel carrying one clipped vertex
interface fscp_out_if import fscp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [PW-1:0] vertex_x;
  logic [DEG_W-1:0]     vertex_y;
  logic                 last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
                output ready);
endinterface

### sv/fscp_cfg_if.sv
`timescale 1ns / 1ps
// configuration write channel for the parallel epsilon register
interface fscp_cfg_if import fscp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [EPS_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/fscp_front.sv
`timescale 1ns / 1ps
// first two pipeline stages: corner differences and flags, then shoulder products
module fscp_front import fscp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [EPS_W-1:0] eps,
  input  logic             in_valid,
  output logic             in_ready,
  input  fscp_set_t        in_set,
  output logic             out_valid,
  input  logic             out_ready,
  output fscp_prod_t       out_data
);

  logic signed [DW-1:0]  a_x, b_x, c_x, d_x;
  logic signed [DW-1:0]  da_c, da_neg;
  logic [PW-1:0]         span;
  fscp_diff_t            s1_nxt, s1_r;
  logic                  s1_v_r, s1_ready;
  fscp_prod_t            s2_nxt, s2_r;
  logic                  s2_v_r, s2_ready;
  logic signed [DEG_W:0] p_s;

  assign a_x    = {in_set.a[PW-1], in_set.a};
  assign b_x    = {in_set.b[PW-1], in_set.b};
  assign c_x    = {in_set.c[PW-1], in_set.c};
  assign d_x    = {in_set.d[PW-1], in_set.d};
  assign da_c   = d_x - a_x;
  assign da_neg = -da_c;
  assign span   = da_c[DW-1] ? da_neg[PW-1:0] : da_c[PW-1:0];

  always_comb begin
    s1_nxt              = '0;
    s1_nxt.set          = in_set;
    s1_nxt.set.p        = (in_set.p > ONE_Q15) ? ONE_Q15 : in_set.p;
    s1_nxt.flags.p_zero = (in_set.p == '0);
    s1_nxt.flags.p_full = (in_set.p >= ONE_Q15);
    s1_nxt.flags.ab_ne  = (in_set.a != in_set.b);
    s1_nxt.flags.bc_eq  = (in_set.b == in_set.c);
    s1_nxt.flags.ad_eq  = (in_set.a == in_set.d);
    s1_nxt.flags.cd_eq  = (in_set.c == in_set.d);
    s1_nxt.flags.narrow = (span == '0) || (span < PW'(eps));
    s1_nxt.ba           = b_x - a_x;
    s1_nxt.dc           = d_x - c_x;
    s1_nxt.da           = da_c;
  end

  assign p_s = {1'b0, s1_r.set.p};

  always_comb begin
    s2_nxt        = '0;
    s2_nxt.set    = s1_r.set;
    s2_nxt.flags  = s1_r.flags;
    s2_nxt.da     = s1_r.da;
    s2_nxt.prod_l = PROD_W'(s1_r.ba) * PROD_W'(p_s);
    s2_nxt.prod_r = PROD_W'(s1_r.dc) * PROD_W'(p_s);
  end

  assign s2_ready  = !s2_v_r || out_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_ready  = s1_ready;
  assign out_valid = s2_v_r;
  assign out_data  = s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (s2_ready && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

### sv/fscp_shoulder.sv
`timescale 1ns / 1ps
// third pipeline stage: rounded shoulders and segment range checks
module fscp_shoulder import fscp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  fscp_prod_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output fscp_shld_t out_data
);

  logic signed [PROD_W-1:0] rnd_l, rnd_r, prod_l_neg;
  logic [PROD_W-1:0]        abs_l, lim;
  logic signed [DW-1:0]     da_neg;
  logic [PW-1:0]            abs_da;
  logic signed [TW-1:0]     da_sh, t_r, t_r_neg;
  logic [TW-1:0]            abs_t;
  logic                     ok_l, ok_r;
  logic signed [PW-1:0]     left_calc, right_calc;
  fscp_shld_t               s3_nxt, s3_r;
  logic                     s3_v_r;

  assign rnd_l      = in_data.prod_l + ROUND_HALF;
  assign rnd_r      = in_data.prod_r + ROUND_HALF;
  assign left_calc  = in_data.set.a + rnd_l[FRAC+PW-1:FRAC];
  assign right_calc = in_data.set.d - rnd_r[FRAC+PW-1:FRAC];

  assign prod_l_neg = -in_data.prod_l;
  assign abs_l      = in_data.prod_l[PROD_W-1] ? prod_l_neg : in_data.prod_l;
  assign da_neg     = -in_data.da;
  assign abs_da     = in_data.da[DW-1] ? da_neg[PW-1:0] : in_data.da[PW-1:0];
  assign lim        = PROD_W'({abs_da, {FRAC{1'b0}}});

  // (d-c)(1-p) + (c-a) folds into (d-a) - (d-c)p
  assign da_sh   = TW'(in_data.da) <<< FRAC;
  assign t_r     = da_sh - TW'(in_data.prod_r);
  assign t_r_neg = -t_r;
  assign abs_t   = t_r[TW-1] ? t_r_neg : t_r;

  assign ok_l = !in_data.flags.narrow && (abs_l <= lim);
  assign ok_r = !in_data.flags.narrow && (abs_t <= TW'(lim));

  always_comb begin
    s3_nxt         = '0;
    s3_nxt.set     = in_data.set;
    s3_nxt.flags   = in_data.flags;
    s3_nxt.left_x  = ok_l ? left_calc : in_data.set.b;
    s3_nxt.right_x = ok_r ? right_calc : in_data.set.c;
  end

  assign in_ready  = !s3_v_r || out_ready;
  assign out_valid = s3_v_r;
  assign out_data  = s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (in_ready) begin
      s3_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

### sv/fscp_emit.sv
`timescale 1ns / 1ps
// vertex list build and one-vertex-per-cycle output register while the output is ready
module fscp_emit import fscp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  fscp_shld_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output fscp_vtx_t  out_vtx,
  output logic       out_last
);

  fscp_vtx_t        lst_nxt [VMAX];
  logic [CNT_W-1:0] cnt_nxt;
  fscp_vtx_t        lst_r [VMAX];
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] idx_r;
  logic             list_v_r;
  logic             out_valid_r, out_last_r;
  fscp_vtx_t        out_vtx_r;
  logic             out_free, emit, at_end, done;

  function automatic fscp_vtx_t mk(input logic signed [PW-1:0] x,
                                   input logic [DEG_W-1:0] y);
    fscp_vtx_t v;
    v.x = x;
    v.y = y;
    return v;
  endfunction

  always_comb begin
    for (int i = 0; i < VMAX; i++) begin
      lst_nxt[i] = '0;
    end
    cnt_nxt = '0;
    if (!in_data.flags.p_zero) begin
      if (in_data.flags.ab_ne) begin
        lst_nxt[cnt_nxt[IDX_W-1:0]] = mk(in_data.set.a, '0);
        cnt_nxt = cnt_nxt + CNT_W'(1);
      end
      if (in_data.flags.bc_eq && in_data.flags.ad_eq) begin
        // singleton
        lst_nxt[cnt_nxt[IDX_W-1:0]] = mk(in_data.set.b, '0);
        cnt_nxt = cnt_nxt + CNT_W'(1);
        lst_nxt[cnt_nxt[IDX_W-1:0]] = mk(in_data.set.b, in_data.set.p);
        cnt_nxt = cnt_nxt + CNT_W'(1);
        lst_nxt[cnt_nxt[IDX_W-1:0]] = mk(in_data.set.b, '0);
        cnt_nxt = cnt_nxt + CNT_W'(1);
      end else if (in_data.flags.p_full) begin
        lst_nxt[cnt_nxt[IDX_W-1:0]] = mk(in_data.set.b, in_data.set.p);
        cnt_nxt = cnt_nxt + CNT_W'(1);
        if (!in_data.flags.bc_eq) begin
          lst_nxt[cnt_nxt[IDX_W-1:0]] = mk(in_data.set.c, in_data.set.p);
          cnt_nxt = cnt_nxt + CNT_W'(1);
        end else if (in_data.flags.cd_eq) begin
          lst_nxt[cnt_nxt[IDX_W-1:0]] = mk(in_data.set.d, '0);
          cnt_nxt = cnt_nxt + CNT_W'(1);
        end
      end else begin
        lst_nxt[cnt_nxt[IDX_W-1:0]] = mk(in_data.left_x, in_data.set.p);
        cnt_nxt = cnt_nxt + CNT_W'(1);
        lst_nxt[cnt_nxt[IDX_W-1:0]] = mk(in_data.right_x, in_data.set.p);
        cnt_nxt = cnt_nxt + CNT_W'(1);
      end
      if (!in_data.flags.cd_eq) begin
        lst_nxt[cnt_nxt[IDX_W-1:0]] = mk(in_data.set.d, '0);
        cnt_nxt = cnt_nxt + CNT_W'(1);
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign at_end   = (CNT_W'(idx_r) == cnt_r - CNT_W'(1));
  assign emit     = list_v_r && (cnt_r != '0) && out_free;
  assign done     = list_v_r && ((cnt_r == '0) || (emit && at_end));
  assign in_ready = !list_v_r || done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_v_r    <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        list_v_r <= 1'b1;
        cnt_r    <= cnt_nxt;
        idx_r    <= '0;
      end else if (done) begin
        list_v_r <= 1'b0;
      end else if (emit) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int i = 0; i < VMAX; i++) begin
        lst_r[i] <= lst_nxt[i];
      end
    end
    if (emit) begin
      out_vtx_r  <= lst_r[idx_r];
      out_last_r <= at_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_vtx   = out_vtx_r;
  assign out_last  = out_last_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    list_v_r && (cnt_r != '0) |-> CNT_W'(idx_r) < cnt_r)
    else $error("vertex index beyond list length");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    list_v_r |-> cnt_r <= CNT_W'(VMAX))
    else $error("vertex list longer than maximum");

  a_list_kept: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !at_end |=> list_v_r && (idx_r == $past(idx_r) + IDX_W'(1)))
    else $error("vertex list dropped before last vertex");

  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    emit && at_end |=> out_valid_r && out_last_r)
    else $error("final vertex not marked");

endmodule

### sv/fuzzy_set_clip_points_top.sv
`timescale 1ns / 1ps
// Clips one trapezoidal fuzzy set (corners A..D, signed Q8.8) at its firing degree
// (Q1.15) and sends the clipped shape's vertices, one per cycle while the output
// is ready, with last_vertex on the final one; a degree of zero yields no vertex.
// Four register stages (differences, products, shoulders, vertex list) sit
// between a request and the vertex output register. A set yields two to five
// vertices; the vertex list stage takes a new set while it passes the last vertex
// of the current set to the output register, or while it drops a set without
// vertices. Write parallel_epsilon only while no request is in flight.
module fuzzy_set_clip_points_top import fscp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fscp_in_if.sink     in_chan,
  fscp_out_if.source  out_chan,
  fscp_cfg_if.sink    cfg_chan
);

  logic [EPS_W-1:0] eps_r;
  fscp_set_t        in_set;
  fscp_prod_t       prod_data;
  logic             prod_valid, prod_ready;
  fscp_shld_t       shld_data;
  logic             shld_valid, shld_ready;
  fscp_vtx_t        vtx;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_chan.valid) begin
      eps_r <= cfg_chan.data;
    end
  end

  assign in_set.a = in_chan.corner_a;
  assign in_set.b = in_chan.corner_b;
  assign in_set.c = in_chan.corner_c;
  assign in_set.d = in_chan.corner_d;
  assign in_set.p = in_chan.firing_degree;

  fscp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .eps       (eps_r),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_set    (in_set),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_data)
  );

  fscp_shoulder u_shoulder (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod_data),
    .out_valid (shld_valid),
    .out_ready (shld_ready),
    .out_data  (shld_data)
  );

  fscp_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (shld_valid),
    .in_ready  (shld_ready),
    .in_data   (shld_data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_vtx   (vtx),
    .out_last  (out_chan.last_vertex)
  );

  assign out_chan.vertex_x = vtx.x;
  assign out_chan.vertex_y = vtx.y;

endmodule

### tb/sv/clip_vertex_pkg.sv
`timescale 1ns / 1ps
// vertex predictor and in-order scoreboard for the fuzzy set clip point bench
package clip_vertex_pkg;
  import fscp_pkg::*;

  localparam longint FULL_DEGREE = 32768;

  typedef struct packed {
    logic signed [PW-1:0] x;
    logic [DEG_W-1:0]     y;
    logic                 last;
  } clip_vertex_t;

  class clip_vertex_board;
    logic [EPS_W-1:0] epsilon;
    clip_vertex_t     vertex_q[$];
    int unsigned      mismatches;

    function new();
      epsilon    = EPS_RESET;
      mismatches = 0;
    endfunction

    function int pending();
      return vertex_q.size();
    endfunction

    function void add_vertex(longint x, longint y);
      clip_vertex_t v;
      v.x    = PW'(x);
      v.y    = DEG_W'(y);
      v.last = 1'b0;
      vertex_q.push_back(v);
    endfunction

    // diff * p / 1.0, rounded to nearest, ties upward
    function longint shoulder_offset(longint diff, longint p);
      return (diff * p + FULL_DEGREE / 2) >>> FRAC;
    endfunction

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function void note_request(fscp_set_t s);
      longint a, b, c, d, p, span, lim, left_x, right_x;
      bit     narrow;
      a = $signed(s.a);
      b = $signed(s.b);
      c = $signed(s.c);
      d = $signed(s.d);
      p = s.p;
      if (p > FULL_DEGREE) p = FULL_DEGREE;
      if (p == 0) return;
      if (a != b) add_vertex(a, 0);
      if (b == c && a == d) begin
        add_vertex(b, 0);
        add_vertex(b, p);
        add_vertex(b, 0);
      end else if (p == FULL_DEGREE) begin
        add_vertex(b, p);
        if (b == c) begin
          if (c == d) add_vertex(d, 0);
        end else begin
          add_vertex(c, p);
        end
      end else begin
        span    = magnitude(d - a);
        lim     = span * FULL_DEGREE;
        narrow  = (span == 0) || (span < longint'(epsilon));
        left_x  = b;
        right_x = c;
        if (!narrow) begin
          if (p * magnitude(b - a) <= lim) left_x = a + shoulder_offset(b - a, p);
          if (magnitude((d - c) * (FULL_DEGREE - p) + (c - a) * FULL_DEGREE) <= lim)
            right_x = d - shoulder_offset(d - c, p);
        end
        add_vertex(left_x, p);
        add_vertex(right_x, p);
      end
      if (c != d) add_vertex(d, 0);
      vertex_q[vertex_q.size() - 1].last = 1'b1;
    endfunction

    function void report(string msg);
      if (mismatches < 10) $display("%s", msg);
      mismatches++;
    endfunction

    function void check_vertex(clip_vertex_t got);
      clip_vertex_t want;
      if (vertex_q.size() == 0) begin
        report($sformatf("unexpected vertex x=%0d y=%0d last=%0b", got.x, got.y, got.last));
        return;
      end
      want = vertex_q.pop_front();
      if (got !== want)
        report($sformatf("vertex mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                         want.x, want.y, want.last, got.x, got.y, got.last));
    endfunction
  endclass

endpackage

### tb/sv/tb_fuzzy_set_clip_points_top.sv
`timescale 1ns / 1ps
// self-checking bench for the fuzzy set clip point block
module tb_fuzzy_set_clip_points_top;
  import fscp_pkg::*;
  import clip_vertex_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;

  typedef enum int {FLOW, SPARSE_STALL, MASK_STALL, COIN_STALL} stall_mode_t;

  logic clk;
  logic rst_n;

  fscp_in_if  in_chan();
  fscp_out_if out_chan();
  fscp_cfg_if cfg_chan();

  clip_vertex_board board = new();

  int unsigned idle_cycles;
  int unsigned hold_asked;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned pattern_left;
  int unsigned pattern_pos;
  stall_mode_t stall_mode;
  logic [31:0] stall_mask;

  fuzzy_set_clip_points_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // accepted requests, vertices and register writes
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      board.note_request({in_chan.corner_a, in_chan.corner_b, in_chan.corner_c,
                          in_chan.corner_d, in_chan.firing_degree});
    if (rst_n && out_chan.valid && out_chan.ready)
      board.check_vertex({out_chan.vertex_x, out_chan.vertex_y, out_chan.last_vertex});
    if (rst_n && cfg_chan.valid && cfg_chan.ready)
      board.epsilon = cfg_chan.data;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
        || (cfg_chan.valid && cfg_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("fuzzy_set_clip_points_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // vertex receiver back-pressure
  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      out_chan.ready <= 1'b0;
      hold_left--;
    end else begin
      if (pattern_left == 0) begin
        stall_mode   = stall_mode_t'($urandom_range(0, 3));
        stall_mask   = $urandom | 32'd1;
        pattern_left = $urandom_range(16, 128);
        pattern_pos  = 0;
      end else begin
        pattern_left--;
      end
      case (stall_mode)
        FLOW:         out_chan.ready <= 1'b1;
        SPARSE_STALL: out_chan.ready <= ($urandom_range(0, 3) != 0);
        MASK_STALL: begin
          out_chan.ready <= stall_mask[pattern_pos % 32];
          pattern_pos++;
        end
        default:      out_chan.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  function automatic fscp_set_t corner_set(int a, int b, int c, int d, int p);
    fscp_set_t s;
    s.a = PW'(a);
    s.b = PW'(b);
    s.c = PW'(c);
    s.d = PW'(d);
    s.p = DEG_W'(p);
    return s;
  endfunction

  function automatic fscp_set_t random_set();
    fscp_set_t s;
    int        pts[4];
    int        kind, width, lo, tmp, i, j, pick;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      s.a = PW'($urandom);
      s.b = PW'($urandom);
      s.c = PW'($urandom);
      s.d = PW'($urandom);
    end else begin
      width = ($urandom_range(0, 3) == 0) ? 65535
                                          : $urandom_range(0, $urandom_range(0, 1) ? 40 : 2000);
      lo = int'($urandom_range(0, 65535 - width)) - 32768;
      for (i = 0; i < 4; i++) pts[i] = lo + int'($urandom_range(0, width));
      for (i = 0; i < 3; i++)
        for (j = 0; j < 3 - i; j++)
          if (pts[j] > pts[j + 1]) begin
            tmp        = pts[j];
            pts[j]     = pts[j + 1];
            pts[j + 1] = tmp;
          end
      case (kind)
        1: pts[1] = pts[0];
        2: pts[2] = pts[1];
        3: pts[3] = pts[2];
        4: begin
          pts[2] = pts[1];
          pts[3] = pts[0];
        end
        5: begin
          i        = $urandom_range(0, 3);
          j        = $urandom_range(0, 3);
          tmp      = pts[i];
          pts[i]   = pts[j];
          pts[j]   = tmp;
        end
        default: ;
      endcase
      s.a = PW'(pts[0]);
      s.b = PW'(pts[1]);
      s.c = PW'(pts[2]);
      s.d = PW'(pts[3]);
    end
    pick = $urandom_range(0, 15);
    case (pick)
      0:       s.p = '0;
      1:       s.p = ONE_Q15;
      2:       s.p = DEG_W'($urandom_range(32769, 65535));
      3:       s.p = DEG_W'($urandom_range(1, 64));
      4:       s.p = DEG_W'($urandom_range(32700, 32767));
      default: s.p = DEG_W'($urandom_range(1, 32767));
    endcase
    return s;
  endfunction

  task automatic send_set(input fscp_set_t s);
    in_chan.corner_a      <= s.a;
    in_chan.corner_b      <= s.b;
    in_chan.corner_c      <= s.c;
    in_chan.corner_d      <= s.d;
    in_chan.firing_degree <= s.p;
    in_chan.valid         <= 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic run_random(input int count, input bit squeeze);
    int sent, burst, gap, i;
    sent = 0;
    if (squeeze) hold_asked++;
    while (sent < count) begin
      burst = squeeze ? count : $urandom_range(1, 12);
      for (i = 0; i < burst && sent < count; i++) begin
        send_set(random_set());
        sent++;
      end
      gap = (squeeze || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_chan.valid <= 1'b0;
  endtask

  task automatic write_epsilon(input logic [EPS_W-1:0] eps);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_chan.data  <= eps;
    cfg_chan.valid <= 1'b1;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.corner_a      = '0;
    in_chan.corner_b      = '0;
    in_chan.corner_c      = '0;
    in_chan.corner_d      = '0;
    in_chan.firing_degree = '0;
    out_chan.ready        = 1'b0;
    cfg_chan.valid        = 1'b0;
    cfg_chan.data         = '0;
    idle_cycles           = 0;
    hold_asked            = 0;
    hold_seen             = 0;
    hold_left             = 0;
    pattern_left          = 0;
    pattern_pos           = 0;
    stall_mode            = FLOW;
    stall_mask            = '1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero degree, full height, partial, saturated degree
    send_set(corner_set(-256, -128, 128, 256, 0));
    send_set(corner_set(-256, -128, 128, 256, 32768));
    send_set(corner_set(-256, -128, 128, 256, 16384));
    send_set(corner_set(-256, -128, 128, 256, 65535));
    send_set(corner_set(-256, -128, 128, 256, 32769));
    send_set(corner_set(-256, -128, 128, 256, 1));
    send_set(corner_set(-256, -128, 128, 256, 32767));
    // triangles
    send_set(corner_set(-512, 0, 0, 512, 32768));
    send_set(corner_set(-512, 0, 0, 512, 10000));
    send_set(corner_set(-100, 200, 200, 200, 32768));
    send_set(corner_set(0, 0, 0, 300, 32768));
    send_set(corner_set(-32768, 0, 0, 32767, 16384));
    // singletons
    send_set(corner_set(100, 100, 100, 100, 1000));
    send_set(corner_set(0, 300, 300, 0, 20000));
    send_set(corner_set(-1, -1, -1, -1, 65535));
    send_set(corner_set(0, 0, 0, 0, 32768));
    // field extremes, unsorted corners, zero span, rounding ties
    send_set(corner_set(-32768, -32768, 32767, 32767, 16384));
    send_set(corner_set(-32768, 32767, 32767, -32768, 5000));
    send_set(corner_set(100, -1000, 2000, 50, 20000));
    send_set(corner_set(5, 3, 8, 5, 12345));
    send_set(corner_set(0, 1, 2, 3, 16384));
    send_set(corner_set(3, 2, 1, 0, 16384));
    send_set(corner_set(32767, -1, -32768, 0, 32768));
    in_chan.valid <= 1'b0;

    write_epsilon(8'd0);
    run_random(80, 1'b0);
    write_epsilon(8'd255);
    run_random(40, 1'b1);
    run_random(40, 1'b0);
    write_epsilon(EPS_W'($urandom_range(2, 254)));
    run_random(80, 1'b0);
    write_epsilon(8'd1);
    run_random(80, 1'b0);
    write_epsilon(EPS_W'($urandom_range(0, 255)));
    run_random(80, 1'b0);
    write_epsilon(8'd40);
    run_random(60, 1'b0);

    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("fuzzy_set_clip_points_top verification clean");
    end else begin
      $display("fuzzy_set_clip_points_top verification failed");
    end
    $finish;
  end

endmodule
